@@ src/nfwc_pkg.sv @@
package nfwc_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int SECT_W  = 8;
    localparam int COUNT_W = 16;
    localparam int KIND_W  = 3;

    // one more bit than the address so the sweep end can hold the array size
    localparam int FILL_W      = ADDR_W + 1;
    localparam int FLASH_DEPTH = 1 << ADDR_W;

    localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROGRAM = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    localparam logic [BYTE_W-1:0]  ERASED_BYTE = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } byte_wr_t;

    typedef struct packed {
        logic               en;
        logic [SECT_W-1:0]  sector;
        logic [COUNT_W-1:0] data;
    } cnt_wr_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
        logic [SECT_W-1:0] sector;
    } item_t;

endpackage

@@ src/nfwc_byte_mem.sv @@
module nfwc_byte_mem (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [nfwc_pkg::ADDR_W-1:0]    rd_addr,
    input  nfwc_pkg::byte_wr_t             wr,
    output logic [nfwc_pkg::BYTE_W-1:0]    rd_data
);

    logic [nfwc_pkg::BYTE_W-1:0] mem [nfwc_pkg::FLASH_DEPTH];
    logic [nfwc_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/nfwc_count_mem.sv @@
module nfwc_count_mem #(
    parameter int NUM_SECTORS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [nfwc_pkg::SECT_W-1:0]    rd_sector,
    input  nfwc_pkg::cnt_wr_t              wr,
    input  logic                           clear_all,
    output logic [nfwc_pkg::COUNT_W-1:0]   rd_count
);

    localparam int SEC_W = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;

    logic [nfwc_pkg::COUNT_W-1:0] mem [NUM_SECTORS];
    logic [nfwc_pkg::COUNT_W-1:0] rd_data_reg;
    logic [SEC_W-1:0]             rd_idx_reg;
    logic [NUM_SECTORS-1:0]       vld_reg;
    logic [NUM_SECTORS-1:0]       vld_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.sector[SEC_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_sector[SEC_W-1:0]];
            rd_idx_reg  <= rd_sector[SEC_W-1:0];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (clear_all)
        begin
            vld_next = '0;
        end
        if (wr.en)
        begin
            vld_next[wr.sector[SEC_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // valid bit is looked at when the data is used, so a clear after the read still counts
    assign rd_count = vld_reg[rd_idx_reg] ? rd_data_reg : '0;

endmodule

@@ src/nor_flash_model_with_wear_count.sv @@
// path: an accepted word is held in the s1 stage, then its result in the output register
// throughput: read, program and counter words are taken one per cycle while the
//   output does not stall; an erase holds the input until its fill is set up, and the
//   fill writes 0xFF one byte per cycle through the byte memory write port
// reset: counters clear at once; the byte array is filled with 0xFF by a pass over
//   all 65536 bytes, during which no word is accepted
module nor_flash_model_with_wear_count #(
    parameter int SECTOR_BYTES = 4096,
    parameter int NUM_SECTORS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [nfwc_pkg::KIND_W-1:0]     kind,
    input  logic [nfwc_pkg::ADDR_W-1:0]     address,
    input  logic [nfwc_pkg::BYTE_W-1:0]     write_data,
    input  logic [nfwc_pkg::SECT_W-1:0]     sector,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [nfwc_pkg::BYTE_W-1:0]     read_data,
    output logic [nfwc_pkg::COUNT_W-1:0]    erase_count,
    output logic                            status
);

    localparam int START_W = nfwc_pkg::SECT_W + nfwc_pkg::FILL_W + 1;
    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic                               state_reg, state_next;
    logic [nfwc_pkg::FILL_W-1:0]        fill_addr_reg, fill_addr_next;
    logic [nfwc_pkg::FILL_W-1:0]        fill_end_reg, fill_end_next;

    logic                               s1_valid_reg;
    nfwc_pkg::item_t                    s1_reg;
    logic                               fwd_hit_reg;
    logic [nfwc_pkg::BYTE_W-1:0]        fwd_data_reg;

    logic                               out_valid_reg;
    logic [nfwc_pkg::BYTE_W-1:0]        read_data_reg, read_data_next;
    logic [nfwc_pkg::COUNT_W-1:0]       erase_count_reg, erase_count_next;
    logic                               status_reg, status_next;

    logic                               accept;
    logic                               out_free;
    logic                               s1_done;
    logic                               s1_sec_ok;
    logic                               s1_is_erase;
    logic [nfwc_pkg::BYTE_W-1:0]        mem_byte;
    logic [nfwc_pkg::BYTE_W-1:0]        cur_byte;
    logic [nfwc_pkg::COUNT_W-1:0]       cur_count;
    logic [START_W-1:0]                 sec_start;
    logic [START_W-1:0]                 sec_stop;
    nfwc_pkg::byte_wr_t                 byte_wr;
    nfwc_pkg::cnt_wr_t                  cnt_wr;
    logic                               clear_all;

    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_done     = s1_valid_reg && out_free;
    assign s1_is_erase = s1_valid_reg && (s1_reg.kind == nfwc_pkg::KIND_ERASE);
    // an erase holds the input until its fill is set up
    assign accept      = in_valid && (state_reg == ST_RUN) && !s1_is_erase
                         && (!s1_valid_reg || s1_done);
    assign in_stall    = !((state_reg == ST_RUN) && !s1_is_erase
                         && (!s1_valid_reg || s1_done));

    assign s1_sec_ok = {1'b0, s1_reg.sector} < (nfwc_pkg::SECT_W + 1)'(NUM_SECTORS);
    assign cur_byte  = fwd_hit_reg ? fwd_data_reg : mem_byte;
    assign sec_start = START_W'(s1_reg.sector) * START_W'(SECTOR_BYTES);
    assign sec_stop  = sec_start + START_W'(SECTOR_BYTES);

    nfwc_byte_mem u_byte_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (address),
        .wr      (byte_wr),
        .rd_data (mem_byte)
    );

    nfwc_count_mem #(
        .NUM_SECTORS (NUM_SECTORS)
    ) u_count_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_sector (sector),
        .wr        (cnt_wr),
        .clear_all (clear_all),
        .rd_count  (cur_count)
    );

    always_comb
    begin
        byte_wr          = '0;
        cnt_wr           = '0;
        clear_all        = 1'b0;
        read_data_next   = '0;
        erase_count_next = '0;
        status_next      = 1'b0;
        state_next       = state_reg;
        fill_addr_next   = fill_addr_reg;
        fill_end_next    = fill_end_reg;

        if (state_reg == ST_FILL)
        begin
            byte_wr.en     = 1'b1;
            byte_wr.addr   = fill_addr_reg[nfwc_pkg::ADDR_W-1:0];
            byte_wr.data   = nfwc_pkg::ERASED_BYTE;
            fill_addr_next = fill_addr_reg + 1'b1;
            if (fill_addr_next == fill_end_reg)
            begin
                state_next = ST_RUN;
            end
        end
        else if (s1_done)
        begin
            unique case (s1_reg.kind)
                nfwc_pkg::KIND_READ:
                begin
                    read_data_next = cur_byte;
                end
                nfwc_pkg::KIND_PROGRAM:
                begin
                    byte_wr.en   = 1'b1;
                    byte_wr.addr = s1_reg.address;
                    byte_wr.data = cur_byte & s1_reg.write_data;
                end
                nfwc_pkg::KIND_ERASE:
                begin
                    if (s1_sec_ok)
                    begin
                        cnt_wr.en     = 1'b1;
                        cnt_wr.sector = s1_reg.sector;
                        cnt_wr.data   = (cur_count == nfwc_pkg::COUNT_MAX) ?
                                        cur_count : cur_count + 1'b1;
                        // a sector that starts past the array only counts
                        if (sec_start < START_W'(nfwc_pkg::FLASH_DEPTH))
                        begin
                            state_next     = ST_FILL;
                            fill_addr_next = sec_start[nfwc_pkg::FILL_W-1:0];
                            fill_end_next  =
                                (sec_stop > START_W'(nfwc_pkg::FLASH_DEPTH)) ?
                                nfwc_pkg::FILL_W'(nfwc_pkg::FLASH_DEPTH) :
                                sec_stop[nfwc_pkg::FILL_W-1:0];
                        end
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                nfwc_pkg::KIND_COUNT:
                begin
                    if (s1_sec_ok)
                    begin
                        erase_count_next = cur_count;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                nfwc_pkg::KIND_CLEAR:
                begin
                    clear_all = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
            fill_end_reg  <= nfwc_pkg::FILL_W'(nfwc_pkg::FLASH_DEPTH);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.kind       <= kind;
            s1_reg.address    <= address;
            s1_reg.write_data <= write_data;
            s1_reg.sector     <= sector;
            // program retiring on the same edge is missed by the memory read
            fwd_hit_reg       <= byte_wr.en && (byte_wr.addr == address);
            fwd_data_reg      <= byte_wr.data;
        end
        if (s1_done)
        begin
            read_data_reg   <= read_data_next;
            erase_count_reg <= erase_count_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign erase_count = erase_count_reg;
    assign status      = status_reg;

endmodule

@@ src/nfwc_checker.sv @@
module nfwc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [nfwc_pkg::KIND_W-1:0]     kind,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [nfwc_pkg::BYTE_W-1:0]     read_data,
    input logic [nfwc_pkg::COUNT_W-1:0]    erase_count,
    input logic                            status
);

    // a held result keeps its fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(erase_count) && $stable(status))
        else $error("stalled result changed");

    // the result is registered in the output register behind the s1 stage, or the output was already held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
        else $error("accepted word gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == nfwc_pkg::KIND_ERASE) |=> in_stall)
        else $error("word accepted right behind an erase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (read_data == '0) && (erase_count == '0))
        else $error("error result carries data");

endmodule

bind nor_flash_model_with_wear_count nfwc_checker u_nfwc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .erase_count (erase_count),
    .status      (status)
);
